### hw/rtl/fmp_pkg.sv
package fmp_pkg;

  localparam int unsigned DEF_MAX_HEIGHT   = 32;
  localparam int unsigned DEF_MAX_WIDTH    = 32;
  localparam int unsigned DEF_MAX_CHANNELS = 16;
  localparam int unsigned DEF_MAX_WINDOW   = 8;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SX = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SY = 3'd7;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [15:0] NEG_INF_HALF = 16'hFC00;

  // Window geometry as seen by the datapath
  typedef struct packed {
    logic [5:0] iw;
    logic [5:0] ih;
    logic [3:0] ww;
    logic [3:0] wh;
    logic [2:0] pt;
    logic [2:0] pl;
    logic [3:0] sx;
    logic [3:0] sy;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // write pixel beat into the store
    logic init;     // latch query, clear accumulator
    logic read;     // issue a store read at the current window position
    logic acc;      // fold the returned pixel into the maximum
    logic last;     // current position is the final one of the window
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pos_valid;  // current window position is inside the input
    logic pos_last;   // current window position is the last one
    logic empty;      // window has no positions, or the channel is out of range
  } dp_sts_t;

  // IEEE ordered a > b on half bit patterns
  function automatic logic half_gt(input logic [15:0] a, input logic [15:0] b);
    logic a_nan;
    logic b_nan;
    logic signed [16:0] ka;
    logic signed [16:0] kb;
    a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
    b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
    ka = a[15] ? -$signed({2'b00, a[14:0]}) : $signed({2'b00, a[14:0]});
    kb = b[15] ? -$signed({2'b00, b[14:0]}) : $signed({2'b00, b[14:0]});
    return !a_nan && !b_nan && (ka > kb);
  endfunction

endpackage

### hw/rtl/fmp_ctrl.sv
module fmp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              req_type,
  input  fmp_pkg::dp_sts_t  sts,
  output logic              busy,
  output logic              out_valid,
  output fmp_pkg::dp_cmd_t  cmd
);
  import fmp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       acc_r, acc_nxt;

  // Issue loads and sequence query windows one position per cycle
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = 1'b0;
    cmd       = '0;
    cmd.acc   = acc_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.init  = 1'b1;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (sts.empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.read = 1'b1;
          cmd.last = sts.pos_last;
          acc_nxt  = sts.pos_valid;
          if (sts.pos_last) state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

### hw/rtl/fmp_dp.sv
module fmp_dp #(
  parameter int unsigned MAX_HEIGHT   = fmp_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_WIDTH    = fmp_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_CHANNELS = fmp_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned MAX_WINDOW   = fmp_pkg::DEF_MAX_WINDOW
) (
  input  logic              clk,
  input  fmp_pkg::cfg_t     cfg,
  input  fmp_pkg::dp_cmd_t  cmd,
  input  logic [4:0]        row,
  input  logic [4:0]        col,
  input  logic [3:0]        channel,
  input  logic [15:0]       pixel_value,
  output fmp_pkg::dp_sts_t  sts,
  output logic [15:0]       pooled_value
);
  import fmp_pkg::*;

  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned HW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned AW = RW + CW + HW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);
  // signed coordinate width: covers 31*15+7 and -7
  localparam int unsigned PW = 11;

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_r;

  logic signed [PW-1:0] y_r, x_r, x0_r;
  logic [FW-1:0] fy_r, fx_r, wh_r, ww_r;
  logic [HW-1:0] ch_r;
  logic          ch_ok_r;
  logic [15:0]   max_r;
  logic [10:0]   ih_eff, iw_eff;
  logic [FW-1:0] wh_sat, ww_sat;
  logic          y_in, x_in;
  logic [AW-1:0] wr_addr, rd_addr;
  logic signed [PW-1:0] y0, x0;
  logic          ld_ok;

  // Clamp sizes to the store and window limits
  assign ih_eff = (11'(cfg.ih) > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : 11'(cfg.ih);
  assign iw_eff = (11'(cfg.iw) > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : 11'(cfg.iw);
  assign wh_sat = (32'(cfg.wh) > MAX_WINDOW) ? FW'(MAX_WINDOW) : FW'(cfg.wh);
  assign ww_sat = (32'(cfg.ww) > MAX_WINDOW) ? FW'(MAX_WINDOW) : FW'(cfg.ww);

  assign y0 = $signed(PW'(row) * PW'(cfg.sy)) - $signed(PW'(cfg.pt));
  assign x0 = $signed(PW'(col) * PW'(cfg.sx)) - $signed(PW'(cfg.pl));

  assign ld_ok = (32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH) &&
                 (32'(channel) < MAX_CHANNELS);
  assign wr_addr = {RW'(row), CW'(col), HW'(channel)};

  // Advance window position, latch query on init
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      y_r     <= y0;
      x_r     <= x0;
      x0_r    <= x0;
      fy_r    <= '0;
      fx_r    <= '0;
      wh_r    <= wh_sat;
      ww_r    <= ww_sat;
      ch_r    <= HW'(channel);
      ch_ok_r <= (32'(channel) < MAX_CHANNELS);
    end else if (cmd.read && !cmd.last) begin
      if (fx_r == ww_r - FW'(1)) begin
        fx_r <= '0;
        x_r  <= x0_r;
        fy_r <= fy_r + FW'(1);
        y_r  <= y_r + PW'(1);
      end else begin
        fx_r <= fx_r + FW'(1);
        x_r  <= x_r + PW'(1);
      end
    end
  end

  assign y_in = (y_r >= 0) && ($signed({1'b0, y_r[PW-2:0]}) < $signed(PW'(ih_eff)));
  assign x_in = (x_r >= 0) && ($signed({1'b0, x_r[PW-2:0]}) < $signed(PW'(iw_eff)));
  assign rd_addr = {RW'(y_r), CW'(x_r), ch_r};

  assign sts.empty     = (wh_r == '0) || (ww_r == '0) || !ch_ok_r;
  assign sts.pos_valid = y_in && x_in;
  assign sts.pos_last  = (fy_r == wh_r - FW'(1)) && (fx_r == ww_r - FW'(1));

  // Store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load && ld_ok) mem[wr_addr] <= pixel_value;
    if (cmd.read) rd_r <= mem[rd_addr];
  end

  // Keep running maximum
  always_ff @(posedge clk) begin
    if (cmd.init) max_r <= NEG_INF_HALF;
    else if (cmd.acc && !half_gt(max_r, rd_r)) max_r <= rd_r;
  end

  assign pooled_value = max_r;

endmodule

### hw/rtl/fp16_max_pool_2d_top.sv
// fp16 2-D max pooling over an NHWC pixel store.
// Input channel: start/busy command handshake; a beat is taken when start is
// high and busy low. in_req_type 0 writes in_pixel_value at (row, col,
// channel); 1 queries the pooled output at (row, col, channel).
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, writable
// while the block is idle; cfg_ready is always high.
// Loads finish in the accepting cycle; busy stays low, one load per cycle.
// A query walks the window one position per cycle through the store's
// single read port, then passes through a drain state to the result
// cycle; an empty window goes from the walk straight to the result.
// out_valid marks the result cycle, and the next beat can be taken in the
// cycle after the result. busy is high until the result cycle ends.
// out_valid pulses for one cycle with out_pooled_value; the receiver has no
// back pressure. Reset restores the register defaults and idles the
// controller; the store contents are undefined until written.
module fp16_max_pool_2d_top #(
  parameter int unsigned MAX_HEIGHT   = fmp_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_WIDTH    = fmp_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_CHANNELS = fmp_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned MAX_WINDOW   = fmp_pkg::DEF_MAX_WINDOW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [4:0]                    in_row,
  input  logic [4:0]                    in_col,
  input  logic [3:0]                    in_channel,
  input  logic [15:0]                   in_pixel_value,
  output logic                          out_valid,
  output logic [15:0]                   out_pooled_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import fmp_pkg::*;

  cfg_t    cfg_r;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.iw <= 6'd32;
      cfg_r.ih <= 6'd32;
      cfg_r.ww <= 4'd2;
      cfg_r.wh <= 4'd2;
      cfg_r.pt <= 3'd0;
      cfg_r.pl <= 3'd0;
      cfg_r.sx <= 4'd2;
      cfg_r.sy <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IW:  cfg_r.iw <= cfg_data[5:0];
        REG_IH:  cfg_r.ih <= cfg_data[5:0];
        REG_WW:  cfg_r.ww <= cfg_data[3:0];
        REG_WH:  cfg_r.wh <= cfg_data[3:0];
        REG_PT:  cfg_r.pt <= cfg_data[2:0];
        REG_PL:  cfg_r.pl <= cfg_data[2:0];
        REG_SX:  cfg_r.sx <= cfg_data[3:0];
        REG_SY:  cfg_r.sy <= cfg_data[3:0];
        default: cfg_r.iw <= cfg_r.iw;
      endcase
    end
  end

  fmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_req_type),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  fmp_dp #(
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_dp (
    .clk          (clk),
    .cfg          (cfg_r),
    .cmd          (cmd),
    .row          (in_row),
    .col          (in_col),
    .channel      (in_channel),
    .pixel_value  (in_pixel_value),
    .sts          (sts),
    .pooled_value (out_pooled_value)
  );

`ifndef SYNTH
  // A result follows only a busy cycle
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without query");
  // Result ends the query
  a_out_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  // Commands never overlap load with read or init
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && (cmd.read || cmd.init))) else $error("command overlap");
`endif

endmodule
